// ===== src/trial_division_prime_test_assert.svh =====
`ifndef TRIAL_DIVISION_PRIME_TEST_ASSERT_SVH
`define TRIAL_DIVISION_PRIME_TEST_ASSERT_SVH

// Checks that a condition implies another condition in the same cycle.
`define TDPT_ASSERT_IMPL(name, clk, rst_n, pre, post) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("trial_division_prime_test: same-cycle check failed");

// Checks that a condition implies another condition in the next cycle.
`define TDPT_ASSERT_NEXT(name, clk, rst_n, pre, post) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("trial_division_prime_test: next-cycle check failed");

`endif

// ===== src/tdpt_pkg.sv =====
package tdpt_pkg;

  localparam int unsigned VALUE_WIDTH_DEF = 32;
  localparam int unsigned FIRST_DIVISOR   = 5;
  localparam int unsigned DIVISOR_STEP    = 6;
  localparam int unsigned PAIR_OFFSET     = 2;
  localparam int unsigned THREE           = 3;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CLASSIFY,
    ST_START_D,
    ST_WAIT_D,
    ST_START_D2,
    ST_WAIT_D2,
    ST_DONE
  } tdpt_state_e;

  typedef enum logic {
    DIV_SEL_D,
    DIV_SEL_D2
  } tdpt_div_sel_e;

  typedef struct packed {
    logic          load;
    logic          div_start;
    tdpt_div_sel_e div_sel;
    logic          d_step;
    logic          set_result;
    logic          result_val;
    logic          publish;
  } tdpt_cmd_t;

  typedef struct packed {
    logic n_neg;
    logic n_le1;
    logic n_le3;
    logic n_even;
    logic n_div3;
    logic div_done;
    logic rem_zero;
    logic quo_lt_d;
    logic out_free;
  } tdpt_status_t;

endpackage

// ===== src/tdpt_div.sv =====
module tdpt_div import tdpt_pkg::*; #(
  parameter int unsigned VALUE_WIDTH = VALUE_WIDTH_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  input  logic [VALUE_WIDTH-1:0] dividend_i,
  input  logic [VALUE_WIDTH-1:0] divisor_i,
  output logic                   done_o,
  output logic [VALUE_WIDTH-1:0] quo_o,
  output logic [VALUE_WIDTH-1:0] rem_o
);

  localparam int unsigned CntWidth = $clog2(VALUE_WIDTH + 1);

  logic                   busy_q, busy_d;
  logic                   done_q, done_d;
  logic [CntWidth-1:0]    cnt_q, cnt_d;
  logic [VALUE_WIDTH-1:0] rem_q, rem_d;
  logic [VALUE_WIDTH-1:0] quo_q, quo_d;
  logic [VALUE_WIDTH-1:0] dvs_q, dvs_d;
  logic [VALUE_WIDTH:0]   shifted;
  logic [VALUE_WIDTH:0]   diff;
  logic                   ge;

  assign shifted = {rem_q, quo_q[VALUE_WIDTH-1]};
  assign diff    = shifted - {1'b0, dvs_q};
  assign ge      = ~diff[VALUE_WIDTH];

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    dvs_d  = dvs_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CntWidth'(VALUE_WIDTH);
      rem_d  = '0;
      quo_d  = dividend_i;
      dvs_d  = divisor_i;
    end else if (busy_q) begin
      rem_d = ge ? diff[VALUE_WIDTH-1:0] : shifted[VALUE_WIDTH-1:0];
      quo_d = {quo_q[VALUE_WIDTH-2:0], ge};
      cnt_d = cnt_q - CntWidth'(1);
      if (cnt_q == CntWidth'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dvs_q <= dvs_d;
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;
  assign rem_o  = rem_q;

endmodule

// ===== src/tdpt_datapath.sv =====
module tdpt_datapath import tdpt_pkg::*; #(
  parameter int unsigned VALUE_WIDTH = VALUE_WIDTH_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic [VALUE_WIDTH-1:0] number_i,
  input  tdpt_cmd_t              cmd_i,
  output tdpt_status_t           status_o,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output logic                   prime_o
);

  localparam int unsigned PadWidth = ((VALUE_WIDTH + 3) / 4) * 4;

  logic [VALUE_WIDTH-1:0] n_q, n_d;
  logic [VALUE_WIDTH-1:0] d_q, d_d;
  logic                   res_q, res_d;
  logic                   out_valid_q, out_valid_d;
  logic                   out_prime_q, out_prime_d;
  logic [VALUE_WIDTH-1:0] divisor;
  logic                   div_done;
  logic [VALUE_WIDTH-1:0] quo;
  logic [VALUE_WIDTH-1:0] rem;
  logic [PadWidth-1:0]    n_pad;

  // Sixteen is one more than a multiple of three, so the nibbles of a value
  // add up to the same residue; a few narrow folds finish the reduction.
  function automatic logic mod3_zero(input logic [PadWidth-1:0] value);
    logic [7:0] nib_sum;
    logic [4:0] fold4;
    logic [2:0] fold2;
    logic [2:0] fold1;
    nib_sum = '0;
    for (int k = 0; k < PadWidth / 4; k++) begin
      nib_sum = nib_sum + 8'(value[4*k +: 4]);
    end
    fold4 = 5'(nib_sum[7:4]) + 5'(nib_sum[3:0]);
    fold2 = 3'(fold4[4]) + 3'(fold4[3:2]) + 3'(fold4[1:0]);
    fold1 = 3'(fold2[2]) + 3'(fold2[1:0]);
    return (fold1 == 3'd0) || (fold1 == 3'(THREE));
  endfunction

  always_comb begin
    case (cmd_i.div_sel)
      DIV_SEL_D:  divisor = d_q;
      DIV_SEL_D2: divisor = d_q + VALUE_WIDTH'(PAIR_OFFSET);
      default:    divisor = d_q;
    endcase
  end

  tdpt_div #(
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (cmd_i.div_start),
    .dividend_i(n_q),
    .divisor_i (divisor),
    .done_o    (div_done),
    .quo_o     (quo),
    .rem_o     (rem)
  );

  always_comb begin
    n_d         = n_q;
    d_d         = d_q;
    res_d       = res_q;
    out_valid_d = out_valid_q;
    out_prime_d = out_prime_q;
    if (cmd_i.load) begin
      n_d = number_i;
      d_d = VALUE_WIDTH'(FIRST_DIVISOR);
    end
    if (cmd_i.d_step) begin
      d_d = d_q + VALUE_WIDTH'(DIVISOR_STEP);
    end
    if (cmd_i.set_result) begin
      res_d = cmd_i.result_val;
    end
    if (cmd_i.publish) begin
      out_valid_d = 1'b1;
      out_prime_d = res_q;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    n_q         <= n_d;
    d_q         <= d_d;
    res_q       <= res_d;
    out_prime_q <= out_prime_d;
  end

  assign n_pad = PadWidth'(n_q);

  always_comb begin
    status_o.n_neg    = n_q[VALUE_WIDTH-1];
    status_o.n_le1    = (n_q[VALUE_WIDTH-1:1] == '0);
    status_o.n_le3    = (n_q[VALUE_WIDTH-1:2] == '0);
    status_o.n_even   = ~n_q[0];
    status_o.n_div3   = mod3_zero(n_pad);
    status_o.div_done = div_done;
    status_o.rem_zero = (rem == '0);
    status_o.quo_lt_d = (quo < d_q);
    status_o.out_free = ~out_valid_q | ~out_stall_i;
  end

  assign out_valid_o = out_valid_q;
  assign prime_o     = out_prime_q;

endmodule

// ===== src/tdpt_ctrl.sv =====
module tdpt_ctrl import tdpt_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         in_valid_i,
  output logic         in_stall_o,
  input  tdpt_status_t status_i,
  output tdpt_cmd_t    cmd_o
);

  tdpt_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d          = state_q;
    cmd_o.load       = 1'b0;
    cmd_o.div_start  = 1'b0;
    cmd_o.div_sel    = DIV_SEL_D;
    cmd_o.d_step     = 1'b0;
    cmd_o.set_result = 1'b0;
    cmd_o.result_val = 1'b0;
    cmd_o.publish    = 1'b0;
    in_stall_o       = (state_q != ST_IDLE);
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_CLASSIFY;
        end
      end
      ST_CLASSIFY: begin
        cmd_o.set_result = 1'b1;
        if (status_i.n_neg || status_i.n_le1) begin
          cmd_o.result_val = 1'b0;
          state_d          = ST_DONE;
        end else if (status_i.n_le3) begin
          cmd_o.result_val = 1'b1;
          state_d          = ST_DONE;
        end else if (status_i.n_even || status_i.n_div3) begin
          cmd_o.result_val = 1'b0;
          state_d          = ST_DONE;
        end else begin
          cmd_o.result_val = 1'b1;
          state_d          = ST_START_D;
        end
      end
      ST_START_D: begin
        cmd_o.div_start = 1'b1;
        cmd_o.div_sel   = DIV_SEL_D;
        state_d         = ST_WAIT_D;
      end
      ST_WAIT_D: begin
        if (status_i.div_done) begin
          if (status_i.quo_lt_d) begin
            cmd_o.set_result = 1'b1;
            cmd_o.result_val = 1'b1;
            state_d          = ST_DONE;
          end else if (status_i.rem_zero) begin
            cmd_o.set_result = 1'b1;
            cmd_o.result_val = 1'b0;
            state_d          = ST_DONE;
          end else begin
            state_d = ST_START_D2;
          end
        end
      end
      ST_START_D2: begin
        cmd_o.div_start = 1'b1;
        cmd_o.div_sel   = DIV_SEL_D2;
        state_d         = ST_WAIT_D2;
      end
      ST_WAIT_D2: begin
        if (status_i.div_done) begin
          if (status_i.rem_zero) begin
            cmd_o.set_result = 1'b1;
            cmd_o.result_val = 1'b0;
            state_d          = ST_DONE;
          end else begin
            cmd_o.d_step = 1'b1;
            state_d      = ST_START_D;
          end
        end
      end
      ST_DONE: begin
        if (status_i.out_free) begin
          cmd_o.publish = 1'b1;
          state_d       = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

// ===== src/trial_division_prime_test.sv =====
// Primality test by trial division over divisors of the form 6k-1 and 6k+1.
// Input channel: in_valid_i, in_stall_o and number_i, a signed value. A
// transaction takes place at a rising edge with in_valid_i high and in_stall_o
// low. The block works on one number at a time and stalls its input until the
// answer has been placed in the output register.
// Output channel: out_valid_o, out_stall_i and prime_o. Exactly one result
// transaction follows each input transaction, in order.
// Negative numbers, zero through three and multiples of two or three are
// settled in the classify state, and their result is published from the
// done state. Otherwise rounds of two divisions follow on the single radix-2
// divider. The number of rounds is about sqrt(n) / 6, so a large prime at
// VALUE_WIDTH = 32 takes about 7700 rounds.
// While a result waits under out_stall_i, the next number is still accepted
// and computed; only its own result waits until the output register is free.
// Reset empties the output register and returns the controller to idle.
module trial_division_prime_test import tdpt_pkg::*; #(
  parameter int unsigned VALUE_WIDTH = VALUE_WIDTH_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic signed [VALUE_WIDTH-1:0] number_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic                          prime_o
);

  tdpt_cmd_t    cmd;
  tdpt_status_t status;

  tdpt_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_stall_o(in_stall_o),
    .status_i  (status),
    .cmd_o     (cmd)
  );

  tdpt_datapath #(
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .number_i   (number_i),
    .cmd_i      (cmd),
    .status_o   (status),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .prime_o    (prime_o)
  );

endmodule

// ===== src/tdpt_checker.sv =====
`include "trial_division_prime_test_assert.svh"

module tdpt_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_stall_o,
  input logic out_valid_o,
  input logic out_stall_i,
  input logic prime_o
);

  logic out_hold;

  assign out_hold = out_valid_o && out_stall_i;

  `TDPT_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_hold, out_valid_o && $stable(prime_o))
  `TDPT_ASSERT_NEXT(a_busy_after_accept, clk_i, rst_ni, in_valid_i && !in_stall_o, in_stall_o)
  `TDPT_ASSERT_IMPL(a_result_from_work, clk_i, rst_ni, $rose(out_valid_o), $past(in_stall_o))

endmodule

bind trial_division_prime_test tdpt_checker u_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (in_valid_i),
  .in_stall_o (in_stall_o),
  .out_valid_o(out_valid_o),
  .out_stall_i(out_stall_i),
  .prime_o    (prime_o)
);

// ===== verif/trial_division_prime_test_tb.sv =====
module trial_division_prime_test_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import tdpt_pkg::*;

  localparam int unsigned VW           = VALUE_WIDTH_DEF;
  localparam int unsigned IDLE_LIMIT   = 2_000_000;
  localparam int unsigned NUM_PROBES   = 24;
  localparam int unsigned NUM_RANDOM   = 80;
  localparam int unsigned TAIL_CYCLES  = 20;

  typedef enum int unsigned {
    STALL_NONE,
    STALL_SOME,
    STALL_HEAVY
  } stall_mode_e;

  typedef struct {
    logic [VW-1:0] number;
    bit            typed;
    logic          prime;
  } probe_t;

  typedef struct {
    logic [VW-1:0] number;
    logic          prime;
  } verdict_t;

  logic                 clk_i;
  logic                 rst_ni = 1'b0;
  logic                 in_valid_i = 1'b0;
  logic                 in_stall_o;
  logic signed [VW-1:0] number_i = '0;
  logic                 out_valid_o;
  logic                 out_stall_i = 1'b0;
  logic                 prime_o;

  verdict_t    verdict_q[$];
  int unsigned error_count = 0;
  int unsigned burst_left = 0;
  int unsigned idle_cycles = 0;
  int unsigned stall_phase = 0;
  stall_mode_e stall_mode = STALL_NONE;

  // Squares of primes sit exactly on the loop bound; 49, 169 and 961 hit
  // the second divisor of a pair.
  probe_t probes [NUM_PROBES] = '{
    '{32'd0,           1'b1, 1'b0},
    '{32'd1,           1'b1, 1'b0},
    '{32'd2,           1'b1, 1'b1},
    '{32'd3,           1'b1, 1'b1},
    '{32'd4,           1'b1, 1'b0},
    '{32'hFFFF_FFFF,   1'b1, 1'b0},
    '{32'h8000_0000,   1'b1, 1'b0},
    '{32'h7FFF_FFFF,   1'b0, 1'b0},
    '{32'h7FFF_FFFE,   1'b1, 1'b0},
    '{32'd5,           1'b0, 1'b0},
    '{32'd7,           1'b0, 1'b0},
    '{32'd9,           1'b0, 1'b0},
    '{32'd11,          1'b0, 1'b0},
    '{32'd13,          1'b0, 1'b0},
    '{32'd25,          1'b0, 1'b0},
    '{32'd35,          1'b0, 1'b0},
    '{32'd49,          1'b0, 1'b0},
    '{32'd121,         1'b0, 1'b0},
    '{32'd143,         1'b0, 1'b0},
    '{32'd169,         1'b0, 1'b0},
    '{32'd289,         1'b0, 1'b0},
    '{32'd529,         1'b0, 1'b0},
    '{32'd961,         1'b0, 1'b0},
    '{32'd2147395600,  1'b1, 1'b0}
  };

  trial_division_prime_test #(
    .VALUE_WIDTH(VW)
  ) i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .number_i   (number_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .prime_o    (prime_o)
  );

  always begin
    clk_i = 1'b1;
    #6;
    clk_i = 1'b0;
    #6;
  end

  function automatic logic prime_verdict(input logic [VW-1:0] value);
    longint unsigned n;
    longint unsigned d;
    if (value[VW-1]) return 1'b0;
    n = value;
    if (n <= 1) return 1'b0;
    if (n <= THREE) return 1'b1;
    if (n % 2 == 0 || n % THREE == 0) return 1'b0;
    for (d = FIRST_DIVISOR; d <= n / d; d += DIVISOR_STEP) begin
      if (n % d == 0 || n % (d + PAIR_OFFSET) == 0) return 1'b0;
    end
    return 1'b1;
  endfunction

  // Mostly small values keep the run short; large positives are built with a
  // small factor so that they are rejected after few rounds.
  function automatic logic [VW-1:0] random_number();
    int unsigned pick;
    int unsigned factor;
    int unsigned top;
    pick = $urandom_range(0, 99);
    if (pick < 50) return VW'($urandom_range(0, 4095));
    if (pick < 70) return VW'($urandom_range(4096, 1 << 20));
    if (pick < 85) return VW'($urandom()) | {1'b1, {(VW-1){1'b0}}};
    factor = $urandom_range(2, 1000);
    top = 32'h7FFF_FFFF / factor;
    return VW'(factor * $urandom_range(top / 2, top));
  endfunction

  task automatic report_mismatch(input string what);
    $display("mismatch at %0t ns: %s", $realtime, what);
    error_count++;
  endtask

  task automatic submit(input logic [VW-1:0] value, input bit typed, input logic answer);
    verdict_t v;
    in_valid_i <= 1'b1;
    number_i   <= value;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    v.number = value;
    v.prime  = typed ? answer : prime_verdict(value);
    verdict_q.push_back(v);
    @(negedge clk_i);
  endtask

  task automatic pace();
    int unsigned gap;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      gap        = $urandom_range(0, 6);
      burst_left = $urandom_range(0, 9);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
    end
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    @(negedge clk_i);
    while (verdict_q.size() != 0) @(negedge clk_i);
  endtask

  always @(negedge clk_i) begin
    if (stall_phase == 0) begin
      stall_mode  <= stall_mode_e'($urandom_range(STALL_NONE, STALL_HEAVY));
      stall_phase <= $urandom_range(20, 80);
    end else begin
      stall_phase <= stall_phase - 1;
    end
    case (stall_mode)
      STALL_NONE: out_stall_i <= 1'b0;
      STALL_SOME: out_stall_i <= 1'($urandom_range(0, 1));
      default:    out_stall_i <= ($urandom_range(0, 3) != 0);
    endcase
  end

  always @(posedge clk_i) begin : check_results
    verdict_t v;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (verdict_q.size() == 0) begin
        report_mismatch($sformatf("result %0b with no number pending", prime_o));
      end else begin
        v = verdict_q.pop_front();
        if (prime_o !== v.prime) begin
          report_mismatch($sformatf("number %0d: prime %b, expected %b",
                                    $signed(v.number), prime_o, v.prime));
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == IDLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int unsigned idx;
    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;
    foreach (probes[i]) begin
      submit(probes[i].number, probes[i].typed, probes[i].prime);
      pace();
    end
    drain();
    for (idx = 0; idx < NUM_RANDOM; idx++) begin
      if (idx == NUM_RANDOM / 2) drain();
      submit(random_number(), 1'b0, 1'b0);
      pace();
    end
    drain();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (error_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+src
src/tdpt_pkg.sv
src/tdpt_div.sv
src/tdpt_datapath.sv
src/tdpt_ctrl.sv
src/trial_division_prime_test.sv
src/tdpt_checker.sv
verif/trial_division_prime_test_tb.sv
